// ----- hdl/slrg_pkg.sv -----
// Package for the subtractive lagged generator: constants, widths and shared types.
`default_nettype none
package slrg_pkg;

	localparam int unsigned VALUE_W = 30;
	localparam int unsigned SEED_W  = 29;
	localparam int unsigned IDX_W   = 6;

	localparam logic [VALUE_W-1:0] LAG_MOD  = 30'd1000000000;
	localparam logic [VALUE_W-1:0] LAG_SEED = 30'd161803398;
	localparam logic [IDX_W-1:0]   LAG_LEN  = 6'd55;
	localparam logic [IDX_W-1:0]   LAG_SPAN = 6'd31;
	localparam logic [IDX_W-1:0]   LAG_MULT = 6'd21;
	localparam logic [1:0]         LAST_PASS = 2'd3;

	localparam logic KIND_DRAW = 1'b0;
	localparam logic KIND_SEED = 1'b1;

	// One request beat as seen by the sequencer
	typedef struct packed {
		logic                     kind;
		logic signed [SEED_W-1:0] seed;
	} slrg_req_t;

endpackage
`default_nettype wire

// ----- hdl/slrg_chan_if.sv -----
// Valid/ready channel interfaces for request and result beats.
`default_nettype none
interface slrg_req_if;
	import slrg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic signed [SEED_W-1:0] seed;
	modport source (output valid, output kind, output seed, input ready);
	modport sink   (input valid, input kind, input seed, output ready);
endinterface

interface slrg_rsp_if;
	import slrg_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ----- hdl/slrg_wrap_sub.sv -----
// Shared subtract unit: a - b, wrapped back into [0, 10^9) by adding the modulus.
`default_nettype none
module slrg_wrap_sub
	import slrg_pkg::*;
(
	input  wire logic [VALUE_W-1:0] a,
	input  wire logic [VALUE_W-1:0] b,
	output logic      [VALUE_W-1:0] y
);

	logic [VALUE_W:0] diff;

	// Subtract with a borrow bit, add the modulus back on borrow
	always_comb begin
		diff = {1'b0, a} - {1'b0, b};
		if (diff[VALUE_W]) begin
			y = diff[VALUE_W-1:0] + LAG_MOD;
		end else begin
			y = diff[VALUE_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/slrg_seq.sv -----
// Sequencer: lag table memory, table build, warm-up passes and draws on one subtract unit.
`default_nettype none
module slrg_seq
	import slrg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire slrg_req_t          req,
	input  wire logic               slot_free,
	output logic                    done,
	output logic      [VALUE_W-1:0] value
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SEED    = 3'd1;
	localparam logic [2:0] ST_FILL    = 3'd2;
	localparam logic [2:0] ST_WARM_RD = 3'd3;
	localparam logic [2:0] ST_WARM_WR = 3'd4;
	localparam logic [2:0] ST_DRAW_RD = 3'd5;
	localparam logic [2:0] ST_DRAW_WR = 3'd6;

	logic [2:0]         state_q;
	logic               built_q;
	logic [IDX_W-1:0]   lead_q;
	logic [IDX_W-1:0]   trail_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   fa_q;
	logic [IDX_W-1:0]   wa_q;
	logic [IDX_W-1:0]   wb_q;
	logic [1:0]         pass_q;
	logic [SEED_W-1:0]  mag_q;
	logic [VALUE_W-1:0] cur_q;
	logic [VALUE_W-1:0] nxt_q;
	logic [VALUE_W-1:0] rda_q;
	logic [VALUE_W-1:0] rdb_q;
	logic [VALUE_W-1:0] mem [LAG_LEN];

	logic               accept;
	logic               build;
	logic [SEED_W-1:0]  seed_u;
	logic [SEED_W-1:0]  seed_mag;
	logic [VALUE_W:0]   seed_diff;
	logic [VALUE_W-1:0] seed_cur;
	logic [IDX_W-1:0]   lead_n;
	logic [IDX_W-1:0]   trail_n;
	logic [IDX_W:0]     fa_sum;
	logic [IDX_W-1:0]   fa_n;
	logic [IDX_W-1:0]   wa_n;
	logic [IDX_W-1:0]   wb_n;
	logic [IDX_W-1:0]   rd_addr_a;
	logic [IDX_W-1:0]   rd_addr_b;
	logic               we;
	logic [IDX_W-1:0]   wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic [VALUE_W-1:0] sub_a;
	logic [VALUE_W-1:0] sub_b;
	logic [VALUE_W-1:0] sub_y;

	// Index step: 1..55, anything out of range restarts at 1
	function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
		if (idx >= LAG_LEN || idx == '0) begin
			return IDX_W'(1);
		end
		return idx + IDX_W'(1);
	endfunction

	// Wrapping step through 0..54
	function automatic logic [IDX_W-1:0] step_addr(input logic [IDX_W-1:0] addr);
		if (addr == LAG_LEN - IDX_W'(1)) begin
			return '0;
		end
		return addr + IDX_W'(1);
	endfunction

	slrg_wrap_sub u_sub (
		.a (sub_a),
		.b (sub_b),
		.y (sub_y)
	);

	// Decode the request and the next indices
	always_comb begin
		req_ready = (state_q == ST_IDLE);
		accept    = req_valid && req_ready;
		build     = !built_q || (req.kind == KIND_SEED && req.seed[SEED_W-1]);
		seed_u    = SEED_W'(req.seed);
		if (req.kind != KIND_SEED) begin
			seed_mag = '0;
		end else if (seed_u[SEED_W-1]) begin
			seed_mag = ~seed_u + SEED_W'(1);
		end else begin
			seed_mag = seed_u;
		end
		seed_diff = {1'b0, LAG_SEED} - {2'b0, mag_q};
		if (seed_diff[VALUE_W]) begin
			seed_cur = VALUE_W'(~seed_diff + (VALUE_W+1)'(1));
		end else begin
			seed_cur = seed_diff[VALUE_W-1:0];
		end
		lead_n  = step_idx(lead_q);
		trail_n = step_idx(trail_q);
		fa_sum  = {1'b0, fa_q} + {1'b0, LAG_MULT};
		if (fa_sum >= {1'b0, LAG_LEN}) begin
			fa_n = IDX_W'(fa_sum - {1'b0, LAG_LEN});
		end else begin
			fa_n = fa_sum[IDX_W-1:0];
		end
		wa_n = step_addr(wa_q);
		wb_n = step_addr(wb_q);
	end

	// Route the memory ports and the subtract unit
	always_comb begin
		rd_addr_a = wa_q;
		rd_addr_b = wb_q;
		if (state_q == ST_DRAW_RD) begin
			rd_addr_a = lead_n - IDX_W'(1);
			rd_addr_b = trail_n - IDX_W'(1);
		end
		// Keep reading the draw operands while the result waits for a free slot
		if (state_q == ST_DRAW_WR) begin
			rd_addr_a = lead_q - IDX_W'(1);
			rd_addr_b = trail_q - IDX_W'(1);
		end
		if (state_q == ST_FILL) begin
			sub_a = cur_q;
			sub_b = nxt_q;
		end else begin
			sub_a = rda_q;
			sub_b = rdb_q;
		end
		we      = 1'b0;
		wr_addr = wa_q;
		wr_data = sub_y;
		unique case (state_q)
			ST_SEED: begin
				we      = 1'b1;
				wr_addr = LAG_LEN - IDX_W'(1);
				wr_data = seed_cur;
			end
			ST_FILL: begin
				we      = 1'b1;
				wr_addr = fa_q;
				wr_data = nxt_q;
			end
			ST_WARM_WR: begin
				we = 1'b1;
			end
			ST_DRAW_WR: begin
				we      = slot_free;
				wr_addr = lead_q - IDX_W'(1);
			end
			default: begin
				we = 1'b0;
			end
		endcase
		done  = (state_q == ST_DRAW_WR) && slot_free;
		value = sub_y;
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			built_q <= 1'b0;
			lead_q  <= '0;
			trail_q <= '0;
			cnt_q   <= '0;
			fa_q    <= '0;
			wa_q    <= '0;
			wb_q    <= '0;
			pass_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= build ? ST_SEED : ST_DRAW_RD;
					end
				end
				ST_SEED: begin
					cnt_q   <= IDX_W'(1);
					fa_q    <= LAG_MULT - IDX_W'(1);
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (cnt_q == LAG_LEN - IDX_W'(1)) begin
						wa_q    <= '0;
						wb_q    <= LAG_SPAN;
						pass_q  <= '0;
						state_q <= ST_WARM_RD;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
						fa_q  <= fa_n;
					end
				end
				ST_WARM_RD: begin
					state_q <= ST_WARM_WR;
				end
				ST_WARM_WR: begin
					wa_q    <= wa_n;
					wb_q    <= wb_n;
					state_q <= ST_WARM_RD;
					if (wa_q == LAG_LEN - IDX_W'(1)) begin
						if (pass_q == LAST_PASS) begin
							lead_q  <= '0;
							trail_q <= LAG_SPAN;
							built_q <= 1'b1;
							state_q <= ST_DRAW_RD;
						end else begin
							pass_q <= pass_q + 2'd1;
						end
					end
				end
				ST_DRAW_RD: begin
					lead_q  <= lead_n;
					trail_q <= trail_n;
					state_q <= ST_DRAW_WR;
				end
				ST_DRAW_WR: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the seed chain values
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= seed_mag;
		end
		if (state_q == ST_SEED) begin
			cur_q <= seed_cur;
			nxt_q <= VALUE_W'(1);
		end else if (state_q == ST_FILL) begin
			cur_q <= nxt_q;
			nxt_q <= sub_y;
		end
	end

	// Lag table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rda_q <= mem[rd_addr_a];
		rdb_q <= mem[rd_addr_b];
	end

	assert property (@(posedge clk) disable iff (!arst_n) built_q |=> built_q)
		else $error("table built flag dropped");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after a result");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !built_q |=> state_q == ST_SEED)
		else $error("first request did not build the table");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAW_WR |-> built_q && lead_q != '0 && lead_q <= LAG_LEN)
		else $error("draw with bad lead index or unbuilt table");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> fa_q < LAG_LEN - IDX_W'(1))
		else $error("fill address out of range");

endmodule
`default_nettype wire

// ----- hdl/subtractive_lagged_random_generator.sv -----
// Top level: request channel, output register and the sequencer.
//
// Subtractive lagged random generator. Each request beat on req asks for one
// draw; each draw returns one result beat on rsp with a value in [0, 10^9).
// A request of kind 1 applies its seed first: a negative seed rebuilds the
// lag table from its magnitude, a non-negative one is ignored once the table
// exists. The first request after reset always builds the table.
// A plain draw reads its two entries, then subtracts, writes back and hands
// the result to the output register. A build first runs one seed write, 54
// fill writes and 4 x 55 warm-up steps (read the two entries, then subtract
// and write back), all on the one subtract unit and the two-read, one-write
// table memory.
// req.ready is high only while the sequencer is idle.
// Reset (arst_n low) clears the indices and the built flag; the table content
// is left as is and is rebuilt by the first request.
// When rsp stalls, the result stays in the output register; the block still
// takes a new request and works on it, and holds its final write until the
// output register is free.
`default_nettype none
module subtractive_lagged_random_generator
	import slrg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	slrg_req_if.sink  req,
	slrg_rsp_if.source rsp
);

	slrg_req_t          req_beat;
	logic               req_ready;
	logic               slot_free;
	logic               done;
	logic [VALUE_W-1:0] seq_value;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;

	always_comb begin
		req_beat.kind = req.kind;
		req_beat.seed = req.seed;
		req.ready     = req_ready;
		slot_free     = !out_valid_q || rsp.ready;
		rsp.valid     = out_valid_q;
		rsp.value     = out_value_q;
	end

	slrg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.req       (req_beat),
		.slot_free (slot_free),
		.done      (done),
		.value     (seq_value)
	);

	// Output register: load on a finished draw, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_value_q <= seq_value;
		end
	end

endmodule
`default_nettype wire

// ----- bench/tb_subtractive_lagged_random_generator.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the subtractive lagged generator: random request/result flow control.
module tb_subtractive_lagged_random_generator
	import slrg_pkg::*;
();

	localparam int N_RANDOM    = 1535;
	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 200;
	localparam int CALM_LO     = 600;
	localparam int CALM_HI     = 900;

	logic clk;
	logic arst_n;

	slrg_req_if req_ch ();
	slrg_rsp_if rsp_ch ();

	subtractive_lagged_random_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Request beats waiting to be offered, and draws still owed by the block
	slrg_req_t          draw_reqs[$];
	logic [VALUE_W-1:0] owed_values[$];

	// Predictor state: lag table, lead/trail positions, built flag
	longint     lag_tbl[55];
	int         lead_pos;
	int         trail_pos;
	bit         tbl_built;

	int         n_items;
	int         beats_sent;
	int         beats_seen;
	int         errors;
	int         quiet_cycles;
	int         hold_left;
	bit         hold_done;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint wrap_mod(longint v);
		return (v < 0) ? v + longint'(LAG_MOD) : v;
	endfunction

	function automatic int next_pos(int p);
		return (p >= int'(LAG_LEN) || p == 0) ? 1 : p + 1;
	endfunction

	// Fill the table from a seed magnitude, then run the four warm-up passes
	task automatic build_lag_tbl(longint mag);
		longint cur;
		longint nxt;
		longint prev;
		int     pos;
		int     ahead;
		cur = longint'(LAG_SEED) - mag;
		if (cur < 0) begin
			cur = -cur;
		end
		cur = cur % longint'(LAG_MOD);
		lag_tbl[int'(LAG_LEN) - 1] = cur;
		nxt = 1;
		for (int i = 1; i < int'(LAG_LEN); i++) begin
			pos = (int'(LAG_MULT) * i) % int'(LAG_LEN);
			prev = nxt;
			lag_tbl[pos - 1] = nxt;
			nxt = wrap_mod(cur - nxt);
			cur = prev;
		end
		for (int k = 0; k <= int'(LAST_PASS); k++) begin
			for (int i = 1; i <= int'(LAG_LEN); i++) begin
				ahead = 1 + (i + int'(LAG_SPAN) - 1) % int'(LAG_LEN);
				lag_tbl[i - 1] = wrap_mod(lag_tbl[i - 1] - lag_tbl[ahead - 1]);
			end
		end
		lead_pos  = 0;
		trail_pos = int'(LAG_SPAN);
		tbl_built = 1'b1;
	endtask

	// Apply the seed if asked, then draw once and queue the value owed
	task automatic predict_draw(slrg_req_t r);
		longint s;
		longint diff;
		s = longint'(r.seed);
		if (r.kind == KIND_SEED) begin
			if (!tbl_built || s < 0) begin
				build_lag_tbl((s < 0) ? -s : s);
			end
		end else if (!tbl_built) begin
			build_lag_tbl(0);
		end
		lead_pos  = next_pos(lead_pos);
		trail_pos = next_pos(trail_pos);
		diff = wrap_mod(lag_tbl[lead_pos - 1] - lag_tbl[trail_pos - 1]);
		lag_tbl[lead_pos - 1] = diff;
		owed_values = {owed_values, diff[VALUE_W-1:0]};
	endtask

	task automatic add_req(logic k, logic signed [SEED_W-1:0] s);
		slrg_req_t r;
		r.kind = k;
		r.seed = s;
		draw_reqs = {draw_reqs, r};
	endtask

	// Sender: retire accepted beats into the predictor, offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind  <= KIND_DRAW;
			req_ch.seed  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_draw('{kind: req_ch.kind, seed: req_ch.seed});
				beats_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (draw_reqs.size() > 0 &&
				    ((beats_sent >= CALM_LO && beats_sent < CALM_HI) ||
				     $urandom_range(99) >= 19)) begin
					req_ch.valid <= 1'b1;
					req_ch.kind  <= draw_reqs[0].kind;
					req_ch.seed  <= draw_reqs[0].seed;
					void'(draw_reqs.pop_front());
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result beat, stall at random, hold off once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (owed_values.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0d",
					         $time, rsp_ch.value);
					errors++;
				end else begin
					if (rsp_ch.value !== owed_values[0]) begin
						$display("%0t: value mismatch, expected %0d, got %0d",
						         $time, owed_values[0], rsp_ch.value);
						errors++;
					end
					void'(owed_values.pop_front());
				end
				beats_seen++;
			end
			if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && beats_seen >= HOLD_AT) begin
				hold_left    <= HOLD_CYCLES;
				hold_done    <= 1'b1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= (beats_seen >= CALM_LO && beats_seen < CALM_HI) ||
				                ($urandom_range(99) >= 19);
			end
		end
	end

	// Watchdog: end the run if neither channel moves a beat for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n && quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [7:0] pick;
		req_ch.valid = 1'b0;
		req_ch.kind  = KIND_DRAW;
		req_ch.seed  = '0;
		rsp_ch.ready = 1'b0;
		arst_n       = 1'b0;
		beats_sent   = 0;
		beats_seen   = 0;
		errors       = 0;
		quiet_cycles = 0;
		tbl_built    = 1'b0;
		lead_pos     = 0;
		trail_pos    = 0;

		// Directed: plain draw before any build, ignored seeds, seed extremes
		add_req(KIND_DRAW, 29'sh0ABCDEF);
		add_req(KIND_DRAW, 29'sd0);
		add_req(KIND_SEED, 29'sd123456);
		add_req(KIND_SEED, 29'sh0FFFFFFF);
		add_req(KIND_SEED, 29'sd0);
		add_req(KIND_SEED, -29'sd1);
		add_req(KIND_DRAW, -29'sd1);
		add_req(KIND_SEED, -29'sd161803398);
		add_req(KIND_DRAW, 29'sh0FFFFFFF);
		add_req(KIND_SEED, 29'sh10000000);
		add_req(KIND_DRAW, 29'sh10000000);
		add_req(KIND_SEED, -29'sd161803399);
		add_req(KIND_SEED, -29'sd161803397);
		add_req(KIND_SEED, 29'sd161803398);
		add_req(KIND_DRAW, 29'sh1FFFFFFF);

		// Random: mostly plain draws, some ignored seeds, a few rebuilds
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = 8'($urandom_range(99));
			if (pick < 4) begin
				add_req(KIND_SEED, {1'b1, 28'($urandom)});
			end else if (pick < 15) begin
				add_req(KIND_SEED, {1'b0, 28'($urandom)});
			end else begin
				add_req(KIND_DRAW, 29'($urandom));
			end
		end
		n_items = draw_reqs.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all beats sent, nothing owed, then a short tail
		do begin
			@(posedge clk);
		end while (beats_sent < n_items || owed_values.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
